>>> hw/rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and types of the bitmap block allocator: map geometry,
// field widths, the action codes and the controller/datapath handshake.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int NUM_BLOCKS    = 4096;
   localparam int MAP_WORD_BITS = 32;
   localparam int MAP_WORDS     = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;

   localparam int INDEX_W = $clog2(NUM_BLOCKS);
   localparam int COUNT_W = $clog2(NUM_BLOCKS + 1);
   localparam int FLOOR_W = 13;
   localparam int BIT_W   = $clog2(MAP_WORD_BITS);
   localparam int WADDR_W = $clog2(MAP_WORDS);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   // Register index of reserved_floor, taken from paddr above the byte lanes.
   localparam logic CSR_IDX_FLOOR = 1'b0;
   localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(22);

   typedef enum logic [1:0] {
      ACT_ALLOC      = 2'd0,
      ACT_FREE       = 2'd1,
      ACT_LOAD_BIT   = 2'd2,
      ACT_LOAD_COUNT = 2'd3
   } action_type;

   typedef struct packed {
      logic capture;       // latch the request fields
      logic rd_first;      // read the word holding the floor, start the scan
      logic rd_target;     // read the word holding the request's block
      logic scan;          // step to the next map word
      logic alloc_commit;  // set the found bit and answer with its index
      logic modify_commit; // write the changed bit of a free or load
      logic load_count;    // load the free counter and answer
      logic fail;          // answer with ok clear, nothing changed
   } dp_cmd_type;

   typedef struct packed {
      action_type action;
      logic       floor_ok;  // floor lies inside the map
      logic       index_ok;  // request's block may be touched
      logic       found;     // the word in hand has a free block
      logic       last_word; // the word in hand is the top of the map
   } dp_sts_type;

endpackage

>>> hw/rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: decodes the captured request, steps the
// map scan one word per cycle and raises the result strobe.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   output bba_pkg::dp_cmd_type cmd,
   input  bba_pkg::dp_sts_type sts
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_ISSUE  = 4'b0010,
      S_SCAN   = 4'b0100,
      S_MODIFY = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_ISSUE;
            end
         end
         S_ISSUE: begin
            unique case (sts.action) inside
               ACT_ALLOC: begin
                  if (sts.floor_ok) begin
                     cmd.rd_first = 1'b1;
                     state_in     = S_SCAN;
                  end else begin
                     cmd.fail = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               ACT_FREE, ACT_LOAD_BIT: begin
                  if (sts.index_ok) begin
                     cmd.rd_target = 1'b1;
                     state_in      = S_MODIFY;
                  end else begin
                     cmd.fail = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               default: begin
                  cmd.load_count = 1'b1;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            if (sts.found) begin
               cmd.alloc_commit = 1'b1;
               state_in         = S_IDLE;
            end else if (sts.last_word) begin
               cmd.fail = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_MODIFY: begin
            cmd.modify_commit = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.alloc_commit | cmd.modify_commit | cmd.load_count | cmd.fail;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Every transaction passes S_ISSUE after its capture in S_IDLE, so strobes never touch.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_IDLE))
      else $error("result given while still working");

   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.alloc_commit, cmd.modify_commit, cmd.load_count, cmd.fail}) <= 1)
      else $error("two answers in one cycle");

endmodule

>>> hw/rtl/bba_datapath.sv
// ----------------------------------------------------------------------------
// bba_datapath
// Used map memory with per-row valid bits, request registers, the
// first-fit word search, the free counter and the result registers.
// ----------------------------------------------------------------------------
module bba_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  bba_pkg::dp_cmd_type           cmd,
   output bba_pkg::dp_sts_type           sts,
   input  logic [bba_pkg::FLOOR_W-1:0]   reserved_floor,
   input  logic [1:0]                    req_action,
   input  logic [bba_pkg::INDEX_W-1:0]   req_block_index,
   input  logic                          req_bit_value,
   input  logic [bba_pkg::COUNT_W-1:0]   req_count_value,
   output logic                          rsp_ok,
   output logic [bba_pkg::INDEX_W-1:0]   rsp_granted_index,
   output logic [bba_pkg::COUNT_W-1:0]   rsp_free_count
);
   import bba_pkg::*;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(NUM_BLOCKS);
   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);

   // Request registers.
   action_type           act_ff;
   logic [INDEX_W-1:0]   blk_ff;
   logic                 bitv_ff;
   logic [COUNT_W-1:0]   cnt_ff;

   // Map storage; a row not yet written since reset reads as all clear.
   logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0]     row_valid_ff;
   logic [MAP_WORD_BITS-1:0] rd_data_ff;
   logic                     rd_valid_ff;
   logic [WADDR_W-1:0]       rd_addr;
   logic                     wr_en;
   logic [WADDR_W-1:0]       wr_addr;
   logic [MAP_WORD_BITS-1:0] wr_data;

   logic [WADDR_W-1:0]       cur_ff, cur_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic                     rsp_ok_ff;
   logic [INDEX_W-1:0]       rsp_granted_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;

   logic [WADDR_W-1:0]       floor_word;
   logic [BIT_W-1:0]         floor_bit;
   logic [WADDR_W-1:0]       blk_word;
   logic [BIT_W-1:0]         blk_bit;
   logic [MAP_WORD_BITS-1:0] word_raw;
   logic [MAP_WORD_BITS-1:0] low_mask;
   logic [MAP_WORD_BITS-1:0] avail;
   logic [BIT_W-1:0]         free_pos;
   logic [MAP_WORD_BITS-1:0] pos_onehot;
   logic [MAP_WORD_BITS-1:0] blk_onehot;
   logic                     respond;

   assign floor_word = reserved_floor[INDEX_W-1:BIT_W];
   assign floor_bit  = reserved_floor[BIT_W-1:0];
   assign blk_word   = blk_ff[INDEX_W-1:BIT_W];
   assign blk_bit    = blk_ff[BIT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= action_type'(req_action);
         blk_ff  <= req_block_index;
         bitv_ff <= req_bit_value;
         cnt_ff  <= req_count_value;
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.action    = act_ff;
      sts.floor_ok  = (reserved_floor < FLOOR_W'(NUM_BLOCKS));
      sts.index_ok  = (COUNT_W'(blk_ff) < COUNT_MAX);
      if (act_ff == ACT_FREE) begin
         sts.index_ok = sts.index_ok && (FLOOR_W'(blk_ff) >= reserved_floor);
      end
      sts.found     = |avail;
      sts.last_word = (cur_ff == LAST_WORD);
   end

   // Word search: blocks below the floor count as used on the floor's word.
   always_comb begin
      word_raw = rd_valid_ff ? rd_data_ff : '0;
      for (int i = 0; i < MAP_WORD_BITS; i++) begin
         low_mask[i] = (cur_ff == floor_word) && (BIT_W'(i) < floor_bit);
      end
      avail    = ~(word_raw | low_mask);
      free_pos = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (avail[i]) begin
            free_pos = BIT_W'(i);
         end
      end
      pos_onehot = MAP_WORD_BITS'(1) << free_pos;
      blk_onehot = MAP_WORD_BITS'(1) << blk_bit;
   end

   // Memory ports.
   always_comb begin
      if (cmd.rd_first) begin
         rd_addr = floor_word;
      end else if (cmd.rd_target) begin
         rd_addr = blk_word;
      end else begin
         rd_addr = cur_ff + WADDR_W'(1);
      end

      cur_in = cur_ff;
      if (cmd.rd_first) begin
         cur_in = floor_word;
      end else if (cmd.scan) begin
         cur_in = cur_ff + WADDR_W'(1);
      end

      wr_en   = cmd.alloc_commit | cmd.modify_commit;
      wr_addr = cmd.alloc_commit ? cur_ff : blk_word;
      if (cmd.alloc_commit) begin
         wr_data = word_raw | pos_onehot;
      end else if (act_ff == ACT_LOAD_BIT && bitv_ff) begin
         wr_data = word_raw | blk_onehot;
      end else begin
         wr_data = word_raw & ~blk_onehot;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= map_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // Free counter; a double free still counts up, saturating at the map size.
   always_comb begin
      count_in = count_ff;
      if (cmd.load_count) begin
         count_in = (cnt_ff > COUNT_MAX) ? COUNT_MAX : cnt_ff;
      end else if (cmd.alloc_commit) begin
         if (count_ff != '0) begin
            count_in = count_ff - COUNT_W'(1);
         end
      end else if (cmd.modify_commit && act_ff == ACT_FREE) begin
         if (count_ff < COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   assign respond = cmd.alloc_commit | cmd.modify_commit | cmd.load_count | cmd.fail;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cur_ff   <= '0;
      end else begin
         count_ff <= count_in;
         cur_ff   <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (respond) begin
         rsp_ok_ff      <= ~cmd.fail;
         rsp_granted_ff <= cmd.alloc_commit ? {cur_ff, free_pos} : '0;
         rsp_count_ff   <= count_in;
      end
   end

   assign rsp_ok            = rsp_ok_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_free_count    = rsp_count_ff;

   a_grant_above_floor: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> (FLOOR_W'({cur_ff, free_pos}) >= reserved_floor))
      else $error("granted a block below the floor");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_MAX)
      else $error("free counter above the map size");

   a_scan_steps: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |=> (cur_ff == $past(cur_ff) + WADDR_W'(1)))
      else $error("scan skipped a map word");

endmodule

>>> hw/rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a one-bit-per-block used map with a
// saturating free-block counter and a programmable reserved floor.
//
//   Channel     Ports                                   Transfer
//   request     start/busy, req_*                       start && !busy
//   result      rsp_valid, rsp_*                        one-cycle strobe
//   registers   psel/penable/pwrite/paddr/pwdata/...    APB write, no waits
//
// A load-count transaction is captured and answers from S_ISSUE; a free or
// load-bit answers from S_MODIFY after S_ISSUE, or from S_ISSUE when its block
// index is rejected. An allocate reads map words in S_SCAN, one word per cycle
// from the floor's word upward, at most 128, or answers from S_ISSUE when the
// floor lies past the map. busy is high from acceptance until the result cycle.
// Reset clears the map at once through per-row valid bits; no clearing pass.
// The receiver takes every result in its strobe cycle.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_action,
   input  logic [bba_pkg::INDEX_W-1:0]          req_block_index,
   input  logic                                 req_bit_value,
   input  logic [bba_pkg::COUNT_W-1:0]          req_count_value,
   output logic                                 rsp_valid,
   output logic                                 rsp_ok,
   output logic [bba_pkg::INDEX_W-1:0]          rsp_granted_index,
   output logic [bba_pkg::COUNT_W-1:0]          rsp_free_count,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [bba_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [bba_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [bba_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                 pready
);
   import bba_pkg::*;

   dp_cmd_type         cmd;
   dp_sts_type         sts;
   logic [FLOOR_W-1:0] floor_ff, floor_in;
   logic               csr_idx;
   logic               csr_wr;

   assign pready  = 1'b1;
   assign csr_idx = paddr[CSR_ADDR_W-1];
   assign csr_wr  = psel & penable & pwrite & pready;

   always_comb begin
      floor_in = floor_ff;
      if (csr_wr && csr_idx == CSR_IDX_FLOOR) begin
         floor_in = pwdata[FLOOR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= FLOOR_RESET;
      end else begin
         floor_ff <= floor_in;
      end
   end

   assign prdata = (csr_idx == CSR_IDX_FLOOR) ? CSR_DATA_W'(floor_ff) : '0;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   bba_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .reserved_floor    (floor_ff),
      .req_action        (req_action),
      .req_block_index   (req_block_index),
      .req_bit_value     (req_bit_value),
      .req_count_value   (req_count_value),
      .rsp_ok            (rsp_ok),
      .rsp_granted_index (rsp_granted_index),
      .rsp_free_count    (rsp_free_count)
   );

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_granted_index == '0))
      else $error("failed transaction carries a block index");

   a_floor_stable_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && $past(busy)) |-> $stable(floor_ff))
      else $error("floor changed during a transaction");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_free_count <= COUNT_W'(NUM_BLOCKS)))
      else $error("reported free count above the map size");

endmodule
